[sv/i2cbb_pkg.sv]
// types and constants of the i2c bit-bang master
package i2cbb_pkg;

  // command codes carried by an input beat
  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_START     = 3'd1,
    MODE_STOP      = 3'd2,
    MODE_SEND_BYTE = 3'd3,
    MODE_READ_ACK  = 3'd4,
    MODE_READ_NACK = 3'd5,
    MODE_WAIT_ACK  = 3'd6,
    MODE_SEND_ACK  = 3'd7
  } cmd_mode_e;

  // pin sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WA_LO   = 5'd5,
    PH_WA_POLL = 5'd6,
    PH_AK_A    = 5'd7,
    PH_AK_B    = 5'd8,
    PH_TX_A    = 5'd9,
    PH_TX_B    = 5'd10,
    PH_TX_C    = 5'd11,
    PH_RX_A    = 5'd12,
    PH_RX_B    = 5'd13
  } phase_e;

  // register indexes on the configuration port
  typedef enum logic {
    REG_ACK_TIMEOUT = 1'b0
  } reg_idx_e;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [2:0] HOLD_LONG         = 3'd3;
  localparam logic [2:0] HOLD_SHORT        = 3'd1;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // one input beat
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_item_t;

  // sequencer state
  typedef struct packed {
    phase_e     phase;
    logic [2:0] delay_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] timeout_cnt;
    logic       scl;
    logic       sda;
    logic       drive;
    logic       error;
    logic       ack_after_read;
    logic [7:0] rx_hold;
  } seq_state_t;

endpackage

[sv/i2c_bit_bang_master.sv]
// i2c bit-bang master: pin sequencer with result skid buffer and apb register
//
// Each input beat is one microsecond tick: a command code (ignored while a
// sequence runs), a byte to send and the sampled sda level. Every input beat
// gives exactly one result beat with the scl/sda/direction levels after that
// tick, busy and done flags, the last received byte and the ack error flag.
// The sequencer state is updated in the cycle the input beat is taken and the
// result is registered in the output register or the skid stage.
// One beat per cycle is sustained while the output does not stall; the single
// state register update sets it. Results sit in an output register backed by
// one skid stage, so an input beat is still taken while one result waits;
// in_stall_o rises only once both hold a beat. It depends on registers only.
// The apb port holds ack_timeout_limit at address 0 (reset 250); pready is
// always high and a write takes setup and access cycles.
// Reset: phase idle, scl/sda high and driven, error clear, no result held.
module i2c_bit_bang_master (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cbb_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cbb_pkg::out_item_t  out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration register
  logic [7:0] ack_limit_q;
  logic       reg_sel;
  logic       cfg_write;

  assign reg_sel   = (paddr[2] == i2cbb_pkg::REG_ACK_TIMEOUT) && (paddr[1:0] == 2'b00);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? {24'd0, ack_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_limit_q <= i2cbb_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_write && reg_sel) begin
      ack_limit_q <= pwdata[7:0];
    end
  end

  // handshake of input beats and the two result slots
  logic                  out_v_q, skid_v_q;
  i2cbb_pkg::out_item_t  out_q, skid_q;
  logic                  push, pop;

  assign in_stall_o  = skid_v_q;
  assign push        = in_valid_i && !skid_v_q;
  assign pop         = out_v_q && !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // entry actions of a phase
  function automatic i2cbb_pkg::seq_state_t enter_phase(
    input i2cbb_pkg::seq_state_t st,
    input i2cbb_pkg::phase_e     ph,
    input logic                  sample
  );
    i2cbb_pkg::seq_state_t r;
    r       = st;
    r.phase = ph;
    case (ph)
      i2cbb_pkg::PH_ST_A: begin
        r.drive = 1'b1; r.sda = 1'b1; r.scl = 1'b1;
        r.delay_cnt = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_ST_B: begin
        r.sda = 1'b0; r.delay_cnt = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_SP_A: begin
        r.drive = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
        r.delay_cnt = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_SP_B: begin
        r.scl = 1'b1; r.sda = 1'b1; r.delay_cnt = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_WA_LO: begin
        r.drive = 1'b0; r.sda = 1'b1; r.delay_cnt = 3'd0;
      end
      i2cbb_pkg::PH_WA_POLL: begin
        r.scl = 1'b1; r.delay_cnt = 3'd0;
      end
      i2cbb_pkg::PH_AK_A: begin
        r.scl = 1'b0; r.drive = 1'b1; r.sda = !st.ack_after_read;
        r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_AK_B: begin
        r.scl = 1'b1; r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_A: begin
        r.scl       = 1'b0;
        r.sda       = st.shift[7];
        r.shift     = {st.shift[6:0], 1'b0};
        r.bit_cnt   = st.bit_cnt + 4'd1;
        r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_B: begin
        r.scl = 1'b1; r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_C: begin
        r.scl = 1'b0; r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_RX_A: begin
        r.scl = 1'b0; r.delay_cnt = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_RX_B: begin
        r.scl       = 1'b1;
        r.shift     = {st.shift[6:0], sample};
        r.bit_cnt   = st.bit_cnt + 4'd1;
        r.delay_cnt = 3'd0;
      end
      default: begin
        r.phase = i2cbb_pkg::PH_IDLE; r.delay_cnt = 3'd0;
      end
    endcase
    return r;
  endfunction

  // sequencer state for one tick
  i2cbb_pkg::seq_state_t state_q, state_d;
  i2cbb_pkg::out_item_t  res_d;
  logic                  done_d;
  logic                  smp;

  assign smp = in_item_i.sda_in;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    if (state_q.phase == i2cbb_pkg::PH_IDLE || state_q.phase > i2cbb_pkg::PH_RX_B) begin
      // idle: take a command
      state_d.phase = i2cbb_pkg::PH_IDLE;
      case (in_item_i.mode)
        i2cbb_pkg::MODE_START: state_d = enter_phase(state_d, i2cbb_pkg::PH_ST_A, smp);
        i2cbb_pkg::MODE_STOP:  state_d = enter_phase(state_d, i2cbb_pkg::PH_SP_A, smp);
        i2cbb_pkg::MODE_SEND_BYTE: begin
          state_d.shift   = in_item_i.tx_byte;
          state_d.bit_cnt = 4'd0;
          state_d.drive   = 1'b1;
          state_d = enter_phase(state_d, i2cbb_pkg::PH_TX_A, smp);
        end
        i2cbb_pkg::MODE_READ_ACK, i2cbb_pkg::MODE_READ_NACK: begin
          state_d.ack_after_read = (in_item_i.mode == i2cbb_pkg::MODE_READ_ACK);
          state_d.shift   = 8'd0;
          state_d.bit_cnt = 4'd0;
          state_d.drive   = 1'b0;
          state_d = enter_phase(state_d, i2cbb_pkg::PH_RX_A, smp);
        end
        i2cbb_pkg::MODE_WAIT_ACK: begin
          state_d.timeout_cnt = 8'd0;
          state_d.error       = 1'b0;
          state_d = enter_phase(state_d, i2cbb_pkg::PH_WA_LO, smp);
        end
        i2cbb_pkg::MODE_SEND_ACK: begin
          state_d.ack_after_read = 1'b1;
          state_d = enter_phase(state_d, i2cbb_pkg::PH_AK_A, smp);
        end
        default: ;
      endcase
    end else if (state_q.delay_cnt != 3'd0) begin
      // hold time
      state_d.delay_cnt = state_q.delay_cnt - 3'd1;
    end else begin
      // end of a phase
      case (state_q.phase)
        i2cbb_pkg::PH_ST_A: state_d = enter_phase(state_q, i2cbb_pkg::PH_ST_B, smp);
        i2cbb_pkg::PH_ST_B, i2cbb_pkg::PH_AK_B: begin
          state_d.scl = 1'b0;
          state_d.phase = i2cbb_pkg::PH_IDLE; state_d.delay_cnt = 3'd0; done_d = 1'b1;
        end
        i2cbb_pkg::PH_SP_A: state_d = enter_phase(state_q, i2cbb_pkg::PH_SP_B, smp);
        i2cbb_pkg::PH_SP_B: begin
          state_d.phase = i2cbb_pkg::PH_IDLE; state_d.delay_cnt = 3'd0; done_d = 1'b1;
        end
        i2cbb_pkg::PH_WA_LO: state_d = enter_phase(state_q, i2cbb_pkg::PH_WA_POLL, smp);
        i2cbb_pkg::PH_WA_POLL: begin
          if (!smp) begin
            state_d.scl = 1'b0;
            state_d.phase = i2cbb_pkg::PH_IDLE; state_d.delay_cnt = 3'd0; done_d = 1'b1;
          end else if (state_q.timeout_cnt >= ack_limit_q) begin
            state_d.error = 1'b1;
            state_d = enter_phase(state_d, i2cbb_pkg::PH_SP_A, smp);
          end else begin
            state_d.timeout_cnt = state_q.timeout_cnt + 8'd1;
          end
        end
        i2cbb_pkg::PH_AK_A: state_d = enter_phase(state_q, i2cbb_pkg::PH_AK_B, smp);
        i2cbb_pkg::PH_TX_A: state_d = enter_phase(state_q, i2cbb_pkg::PH_TX_B, smp);
        i2cbb_pkg::PH_TX_B: state_d = enter_phase(state_q, i2cbb_pkg::PH_TX_C, smp);
        i2cbb_pkg::PH_TX_C: begin
          if (state_q.bit_cnt < i2cbb_pkg::BITS_PER_BYTE) begin
            state_d = enter_phase(state_q, i2cbb_pkg::PH_TX_A, smp);
          end else begin
            state_d.phase = i2cbb_pkg::PH_IDLE; state_d.delay_cnt = 3'd0; done_d = 1'b1;
          end
        end
        i2cbb_pkg::PH_RX_A: state_d = enter_phase(state_q, i2cbb_pkg::PH_RX_B, smp);
        i2cbb_pkg::PH_RX_B: begin
          if (state_q.bit_cnt < i2cbb_pkg::BITS_PER_BYTE) begin
            state_d = enter_phase(state_q, i2cbb_pkg::PH_RX_A, smp);
          end else begin
            state_d.rx_hold = state_q.shift;
            state_d = enter_phase(state_d, i2cbb_pkg::PH_AK_A, smp);
          end
        end
        default: begin
          state_d.phase = i2cbb_pkg::PH_IDLE; state_d.delay_cnt = 3'd0;
        end
      endcase
    end
  end

  // result of this tick
  always_comb begin
    res_d.scl_level = state_d.scl;
    res_d.sda_level = state_d.sda;
    res_d.sda_drive = state_d.drive;
    res_d.busy_res  = (state_d.phase != i2cbb_pkg::PH_IDLE);
    res_d.done_res  = done_d;
    res_d.rx_byte   = state_d.rx_hold;
    res_d.ack_error = state_d.error;
  end

  // state register, advanced on every input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= i2cbb_pkg::PH_IDLE;
      state_q.delay_cnt      <= 3'd0;
      state_q.bit_cnt        <= 4'd0;
      state_q.shift          <= 8'd0;
      state_q.timeout_cnt    <= 8'd0;
      state_q.scl            <= 1'b1;
      state_q.sda            <= 1'b1;
      state_q.drive          <= 1'b1;
      state_q.error          <= 1'b0;
      state_q.ack_after_read <= 1'b0;
      state_q.rx_hold        <= 8'd0;
    end else if (push) begin
      state_q <= state_d;
    end
  end

  // output register and skid stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      out_v_q  <= 1'b1;
      skid_v_q <= out_v_q;
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (push && !out_v_q) begin
      out_q <= res_d;
    end
    if (push && out_v_q && !pop) begin
      skid_q <= res_d;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a beat while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_stall_i))
    else $error("skid stage loaded without a stalled output");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("done pulse while still busy");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && state_q.phase == i2cbb_pkg::PH_IDLE
     && in_item_i.mode == i2cbb_pkg::MODE_NONE)
    |=> (state_q.phase == i2cbb_pkg::PH_IDLE))
    else $error("sequence started without a command");

endmodule

[dv/tb_i2c_bit_bang_master.sv]
// testbench for the i2c bit-bang master: pin sequence prediction and beat-by-beat checks
`timescale 1ns / 100ps

module tb_i2c_bit_bang_master;

  localparam int unsigned       CYCLE_LIMIT      = 400000;
  localparam int unsigned       HOLD_OFF_CYCLES  = 64;
  localparam logic [2:0]        ADDR_ACK_TIMEOUT = 3'(4 * i2cbb_pkg::REG_ACK_TIMEOUT);

  // how the sda pin answers during one command
  typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW, SDA_LATE} sda_pol_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  i2cbb_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall;
  i2cbb_pkg::out_item_t out_item;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int unsigned          snd_idle_pct;
  int unsigned          rcv_idle_pct;
  logic                 hold_off_req;
  int unsigned          tick_cnt;
  int unsigned          cyc_cnt;
  int unsigned          fails;
  i2cbb_pkg::out_item_t pin_expect_q[$];

  // predicted sequencer state and configuration
  i2cbb_pkg::phase_e    seq_ph;
  logic [2:0]           seq_dly;
  logic [3:0]           seq_bits;
  logic [7:0]           seq_shift;
  logic [7:0]           seq_tmo;
  logic [7:0]           seq_rx;
  logic                 seq_scl;
  logic                 seq_sda;
  logic                 seq_drv;
  logic                 seq_err;
  logic                 seq_ackrd;
  logic                 seq_done;
  logic [7:0]           tmo_limit;

  i2c_bit_bang_master u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("** i2c_bit_bang_master: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer prediction

  function automatic void seq_clear();
    seq_ph    = i2cbb_pkg::PH_IDLE;
    seq_dly   = '0;
    seq_bits  = '0;
    seq_shift = '0;
    seq_tmo   = '0;
    seq_rx    = '0;
    seq_scl   = 1'b1;
    seq_sda   = 1'b1;
    seq_drv   = 1'b1;
    seq_err   = 1'b0;
    seq_ackrd = 1'b0;
    seq_done  = 1'b0;
    tmo_limit = i2cbb_pkg::ACK_TIMEOUT_RESET;
  endfunction

  // pin levels and hold time on entering a phase
  function automatic void seq_enter(i2cbb_pkg::phase_e ph, logic smp);
    seq_ph = ph;
    case (ph)
      i2cbb_pkg::PH_ST_A: begin
        seq_drv = 1'b1; seq_sda = 1'b1; seq_scl = 1'b1; seq_dly = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_ST_B: begin
        seq_sda = 1'b0; seq_dly = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_SP_A: begin
        seq_drv = 1'b1; seq_scl = 1'b0; seq_sda = 1'b0; seq_dly = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_SP_B: begin
        seq_scl = 1'b1; seq_sda = 1'b1; seq_dly = i2cbb_pkg::HOLD_LONG;
      end
      i2cbb_pkg::PH_WA_LO: begin
        seq_drv = 1'b0; seq_sda = 1'b1; seq_dly = '0;
      end
      i2cbb_pkg::PH_WA_POLL: begin
        seq_scl = 1'b1; seq_dly = '0;
      end
      i2cbb_pkg::PH_AK_A: begin
        seq_scl = 1'b0; seq_drv = 1'b1; seq_sda = ~seq_ackrd;
        seq_dly = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_AK_B: begin
        seq_scl = 1'b1; seq_dly = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_A: begin
        seq_scl   = 1'b0;
        seq_sda   = seq_shift[7];
        seq_shift = {seq_shift[6:0], 1'b0};
        seq_bits  = seq_bits + 4'd1;
        seq_dly   = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_B: begin
        seq_scl = 1'b1; seq_dly = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_TX_C, i2cbb_pkg::PH_RX_A: begin
        seq_scl = 1'b0; seq_dly = i2cbb_pkg::HOLD_SHORT;
      end
      i2cbb_pkg::PH_RX_B: begin
        seq_scl   = 1'b1;
        seq_shift = {seq_shift[6:0], smp};
        seq_bits  = seq_bits + 4'd1;
        seq_dly   = '0;
      end
      default: begin
        seq_ph = i2cbb_pkg::PH_IDLE; seq_dly = '0;
      end
    endcase
  endfunction

  function automatic void seq_end();
    seq_ph   = i2cbb_pkg::PH_IDLE;
    seq_dly  = '0;
    seq_done = 1'b1;
  endfunction

  // step out of a phase once its hold time has run out
  function automatic void seq_advance(logic smp);
    case (seq_ph)
      i2cbb_pkg::PH_ST_A:  seq_enter(i2cbb_pkg::PH_ST_B, smp);
      i2cbb_pkg::PH_ST_B:  begin seq_scl = 1'b0; seq_end(); end
      i2cbb_pkg::PH_SP_A:  seq_enter(i2cbb_pkg::PH_SP_B, smp);
      i2cbb_pkg::PH_SP_B:  seq_end();
      i2cbb_pkg::PH_WA_LO: seq_enter(i2cbb_pkg::PH_WA_POLL, smp);
      i2cbb_pkg::PH_WA_POLL: begin
        if (!smp) begin
          seq_scl = 1'b0;
          seq_end();
        end else if (seq_tmo >= tmo_limit) begin
          seq_err = 1'b1;
          seq_enter(i2cbb_pkg::PH_SP_A, smp);
        end else begin
          seq_tmo = seq_tmo + 8'd1;
        end
      end
      i2cbb_pkg::PH_AK_A:  seq_enter(i2cbb_pkg::PH_AK_B, smp);
      i2cbb_pkg::PH_AK_B:  begin seq_scl = 1'b0; seq_end(); end
      i2cbb_pkg::PH_TX_A:  seq_enter(i2cbb_pkg::PH_TX_B, smp);
      i2cbb_pkg::PH_TX_B:  seq_enter(i2cbb_pkg::PH_TX_C, smp);
      i2cbb_pkg::PH_TX_C: begin
        if (seq_bits < i2cbb_pkg::BITS_PER_BYTE) seq_enter(i2cbb_pkg::PH_TX_A, smp);
        else seq_end();
      end
      i2cbb_pkg::PH_RX_A:  seq_enter(i2cbb_pkg::PH_RX_B, smp);
      i2cbb_pkg::PH_RX_B: begin
        if (seq_bits < i2cbb_pkg::BITS_PER_BYTE) begin
          seq_enter(i2cbb_pkg::PH_RX_A, smp);
        end else begin
          seq_rx = seq_shift;
          seq_enter(i2cbb_pkg::PH_AK_A, smp);
        end
      end
      default: begin seq_ph = i2cbb_pkg::PH_IDLE; seq_dly = '0; end
    endcase
  endfunction

  // one tick: returns the pin levels and flags after it
  function automatic i2cbb_pkg::out_item_t pins_after_tick(i2cbb_pkg::in_item_t it);
    i2cbb_pkg::out_item_t r;
    seq_done = 1'b0;
    if (seq_ph == i2cbb_pkg::PH_IDLE) begin
      case (i2cbb_pkg::cmd_mode_e'(it.mode))
        i2cbb_pkg::MODE_START: seq_enter(i2cbb_pkg::PH_ST_A, it.sda_in);
        i2cbb_pkg::MODE_STOP:  seq_enter(i2cbb_pkg::PH_SP_A, it.sda_in);
        i2cbb_pkg::MODE_SEND_BYTE: begin
          seq_shift = it.tx_byte; seq_bits = '0; seq_drv = 1'b1;
          seq_enter(i2cbb_pkg::PH_TX_A, it.sda_in);
        end
        i2cbb_pkg::MODE_READ_ACK, i2cbb_pkg::MODE_READ_NACK: begin
          seq_ackrd = (i2cbb_pkg::cmd_mode_e'(it.mode) == i2cbb_pkg::MODE_READ_ACK);
          seq_shift = '0; seq_bits = '0; seq_drv = 1'b0;
          seq_enter(i2cbb_pkg::PH_RX_A, it.sda_in);
        end
        i2cbb_pkg::MODE_WAIT_ACK: begin
          seq_tmo = '0; seq_err = 1'b0;
          seq_enter(i2cbb_pkg::PH_WA_LO, it.sda_in);
        end
        i2cbb_pkg::MODE_SEND_ACK: begin
          seq_ackrd = 1'b1;
          seq_enter(i2cbb_pkg::PH_AK_A, it.sda_in);
        end
        default: ;
      endcase
    end else if (seq_dly != '0) begin
      seq_dly = seq_dly - 3'd1;
    end else begin
      seq_advance(it.sda_in);
    end
    r.scl_level = seq_scl;
    r.sda_level = seq_sda;
    r.sda_drive = seq_drv;
    r.busy_res  = (seq_ph != i2cbb_pkg::PH_IDLE);
    r.done_res  = seq_done;
    r.rx_byte   = seq_rx;
    r.ack_error = seq_err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : chk_results
    i2cbb_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pin_expect_q.size() == 0) begin
        $error("result beat with no expectation pending");
        fails++;
      end else begin
        want = pin_expect_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_item.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(out_item.sda_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_item.sda_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(out_item.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_item.done_res));
        check_field("rx_byte", want.rx_byte, out_item.rx_byte);
        check_field("ack_error", 8'(want.ack_error), 8'(out_item.ack_error));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic logic pick_sda(sda_pol_e pol);
    case (pol)
      SDA_HIGH: return 1'b1;
      SDA_LOW:  return 1'b0;
      SDA_LATE: return ($urandom_range(5) != 0);
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  // offer one tick beat and predict its result once taken
  task automatic send_tick(i2cbb_pkg::in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pin_expect_q.push_back(pins_after_tick(it));
    tick_cnt++;
  endtask

  // issue a command and keep ticking until the sequence is over
  task automatic run_cmd(i2cbb_pkg::cmd_mode_e m, logic [7:0] tx, sda_pol_e pol,
                         i2cbb_pkg::cmd_mode_e busy_cmd);
    send_tick(i2cbb_pkg::in_item_t'{mode: m, tx_byte: tx, sda_in: pick_sda(pol)});
    while (seq_ph != i2cbb_pkg::PH_IDLE)
      send_tick(i2cbb_pkg::in_item_t'{mode: busy_cmd, tx_byte: 8'($urandom),
                                      sda_in: pick_sda(pol)});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the ack timeout while nothing is in flight, then read it back
  task automatic set_timeout_limit(logic [7:0] lim);
    logic [31:0] rd;
    wait_drained();
    apb_write(ADDR_ACK_TIMEOUT, {24'd0, lim});
    tmo_limit = lim;
    apb_read(ADDR_ACK_TIMEOUT, rd);
    if (rd !== {24'd0, lim}) begin
      $error("ack_timeout_limit: expected %0h, got %0h", {24'd0, lim}, rd);
      fails++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // every command at least once, byte extremes, commands while busy, idle ticks
  task automatic test_directed();
    run_cmd(i2cbb_pkg::MODE_START, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_SEND_BYTE, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'h00, SDA_LOW, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_SEND_BYTE, 8'hFF, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'hFF, SDA_LATE, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_READ_ACK, 8'h00, SDA_HIGH, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_READ_NACK, 8'hFF, SDA_LOW, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_READ_ACK, 8'h5A, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_SEND_ACK, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    // commands offered on every busy tick, the done tick too, are dropped
    run_cmd(i2cbb_pkg::MODE_STOP, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_START);
    repeat (3)
      send_tick(i2cbb_pkg::in_item_t'{mode: i2cbb_pkg::MODE_NONE, tx_byte: 8'hFF,
                                      sda_in: 1'b0});
    run_cmd(i2cbb_pkg::MODE_START, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_SEND_BYTE);
    run_cmd(i2cbb_pkg::MODE_SEND_BYTE, 8'hA5, SDA_RANDOM, i2cbb_pkg::MODE_READ_ACK);
    run_cmd(i2cbb_pkg::MODE_STOP, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
  endtask

  // ack timeout at the limit extremes, error flag hold and clear
  task automatic test_ack_timeout();
    set_timeout_limit(8'd0);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'h00, SDA_HIGH, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_SEND_BYTE, 8'h3C, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'h00, SDA_LOW, i2cbb_pkg::MODE_NONE);
    // count stops at the limit of 255 before it can wrap, so the 256th high sample ends the wait
    set_timeout_limit(8'd255);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'h00, SDA_HIGH, i2cbb_pkg::MODE_WAIT_ACK);
    set_timeout_limit(i2cbb_pkg::ACK_TIMEOUT_RESET);
    run_cmd(i2cbb_pkg::MODE_WAIT_ACK, 8'h00, SDA_LATE, i2cbb_pkg::MODE_NONE);
  endtask

  // random commands from idle with random bytes and sda answers
  task automatic test_random(int unsigned snd, int unsigned rcv, logic [7:0] lim,
                             int unsigned ticks);
    int unsigned          stop_at;
    i2cbb_pkg::cmd_mode_e m;
    i2cbb_pkg::cmd_mode_e busy_cmd;
    sda_pol_e             pol;
    set_timeout_limit(lim);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    stop_at = tick_cnt + ticks;
    while (tick_cnt < stop_at) begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1))
          send_tick(i2cbb_pkg::in_item_t'{mode: i2cbb_pkg::MODE_NONE,
                                          tx_byte: 8'($urandom),
                                          sda_in: 1'($urandom)});
      m   = i2cbb_pkg::cmd_mode_e'($urandom_range(7, 1));
      pol = SDA_RANDOM;
      if (m == i2cbb_pkg::MODE_WAIT_ACK) pol = ($urandom_range(3) == 0) ? SDA_HIGH : SDA_LATE;
      busy_cmd = ($urandom_range(3) == 0) ? i2cbb_pkg::cmd_mode_e'($urandom_range(7))
                                          : i2cbb_pkg::MODE_NONE;
      run_cmd(m, 8'($urandom), pol, busy_cmd);
    end
  endtask

  // long receiver hold-off fills the output side and stalls the input
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_off_req = 1'b1;
    run_cmd(i2cbb_pkg::MODE_START, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_SEND_BYTE, 8'($urandom), SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    run_cmd(i2cbb_pkg::MODE_READ_NACK, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
    // pause until every beat is back, then carry on
    wait_drained();
    run_cmd(i2cbb_pkg::MODE_STOP, 8'h00, SDA_RANDOM, i2cbb_pkg::MODE_NONE);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_off_req = 1'b0;
    tick_cnt     = 0;
    cyc_cnt      = 0;
    fails        = 0;
    snd_idle_pct = 36;
    rcv_idle_pct = 72;
    seq_clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_ack_timeout();
    test_random(36, 72, 8'($urandom_range(12, 1)), 160);
    test_random(72, 36, 8'd0, 160);
    test_random(0, 0, 8'($urandom_range(60, 30)), 160);
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails == 0 && pin_expect_q.size() == 0) begin
      $display("** i2c_bit_bang_master: PASSED **");
    end else begin
      $display("** i2c_bit_bang_master: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
sv/i2cbb_pkg.sv
sv/i2c_bit_bang_master.sv
dv/tb_i2c_bit_bang_master.sv
